### src/srt_pkg.sv
// Package for the sorted record table: sizes, action and status codes, payload words.
// No dependencies.
package srt_pkg;
  localparam int unsigned Capacity = 32;
  localparam int unsigned IdxW = $clog2(Capacity);
  localparam int unsigned CntW = $clog2(Capacity + 1);
  localparam int unsigned RecW = 56 + 21 + 16;
  localparam int unsigned QDepth = 2;

  localparam logic [1:0] ActInsert = 2'd0;
  localparam logic [1:0] ActFind   = 2'd1;
  localparam logic [1:0] ActRemove = 2'd2;
  localparam logic [1:0] ActNone   = 2'd3;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StFull    = 2'd1;
  localparam logic [1:0] StNoMatch = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [55:0] record_key;
    logic [4:0]  birth_day;
    logic [3:0]  birth_month;
    logic [11:0] birth_year;
    logic [15:0] record_handle;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [55:0] found_key;
    logic [4:0]  found_day;
    logic [3:0]  found_month;
    logic [11:0] found_year;
    logic [15:0] found_handle;
    logic [5:0]  removed_count;
    logic        last;
  } out_word_t;

  // Record layout in storage: key, date (year, month, day), handle.
  typedef struct packed {
    logic [55:0] key;
    logic [20:0] date;
    logic [15:0] handle;
  } rec_t;
endpackage

### src/srt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module srt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### src/srt_front.sv
// Front end: accepts words, drops unused actions, queues the rest for the engine.
// Depends on srt_pkg.
module srt_front import srt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_word_t in_data_i,
  output logic     q_valid_o,
  input  logic     q_pop_i,
  output in_word_t q_data_o
);
  localparam int unsigned PW = $clog2(QDepth);
  in_word_t        buf_q [QDepth];
  logic [PW-1:0]   wp_q, rp_q;
  logic [PW:0]     cnt_q;
  logic            push, pop;

  assign in_ready_o = (cnt_q != (PW+1)'(QDepth));
  assign push       = in_valid_i && in_ready_o && (in_data_i.action != ActNone);
  assign pop        = q_pop_i && q_valid_o;
  assign q_valid_o  = (cnt_q != '0);
  assign q_data_o   = buf_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wp_q] <= in_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push) wp_q <= (wp_q == PW'(QDepth - 1)) ? '0 : wp_q + 1'b1;
      if (pop)  rp_q <= (rp_q == PW'(QDepth - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PW+1)'(QDepth)) else $error("queue overfilled");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |=> !($past(pop))) else $error("pop of empty queue");
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count slip");
endmodule

### src/srt_engine.sv
// Back end: walks the record table one entry a cycle when not stalled or held by an insert; two RAMs in ping-pong.
// Depends on srt_pkg and srt_ram.
module srt_engine import srt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  output logic      cmd_pop_o,
  input  in_word_t  cmd_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_data_o
);
  // Each command that runs copies the live bank into the other bank, editing on the way;
  // after an insert or a remove the banks then swap.
  localparam logic [1:0] SIdle = 2'd0, SRun = 2'd1, SDone = 2'd2;
  logic [1:0]     st_q, st_d;
  logic           bank_q;
  logic [CntW-1:0] cnt_q, rd_q, wr_q;
  logic [CntW-1:0] rd_prev;
  logic           rv_q;     // read data valid this cycle
  logic           ins_done_q;
  in_word_t       cmd_q;
  logic [5:0]     rem_q;
  logic           found_q;
  out_word_t      pend_q;   // newest match of a find, sent when the next turns up or at the close
  rec_t           rd0, rd1, rdat, wdat;
  logic           we0, we1, we;
  logic [IdxW-1:0] waddr, raddr;
  logic [20:0]    cdate;
  logic           ov_q, ov_d;
  out_word_t      ow_q, ow_d;
  logic           out_free, emit, ins_now, ins_tail, keep, stall, hold;
  out_word_t      ew;

  assign cdate   = {cmd_q.birth_year, cmd_q.birth_month, cmd_q.birth_day};
  assign rdat    = bank_q ? rd1 : rd0;
  // entry 0 is fetched while idle; a held entry is fetched again
  assign hold    = ins_now || stall;
  assign rd_prev = rd_q - 1'b1;
  assign raddr   = (st_q == SIdle) ? '0 : (hold ? rd_prev[IdxW-1:0] : rd_q[IdxW-1:0]);
  assign waddr   = wr_q[IdxW-1:0];
  assign we0     = we && !stall && bank_q;
  assign we1     = we && !stall && !bank_q;

  srt_ram #(.Width(RecW), .Depth(Capacity)) u_ram0 (
    .clk_i, .we_i(we0), .waddr_i(waddr), .wdata_i(wdat), .raddr_i(raddr), .rdata_o(rd0));
  srt_ram #(.Width(RecW), .Depth(Capacity)) u_ram1 (
    .clk_i, .we_i(we1), .waddr_i(waddr), .wdata_i(wdat), .raddr_i(raddr), .rdata_o(rd1));

  assign out_free    = !ov_q || out_ready_i;
  assign out_valid_o = ov_q;
  assign out_data_o  = ow_q;
  assign cmd_pop_o   = (st_q == SIdle) && cmd_valid_i;

  // Per-cycle decisions while running.
  always_comb begin
    we = 1'b0; wdat = rdat; emit = 1'b0; ew = '0; ins_now = 1'b0; ins_tail = 1'b0;
    keep = 1'b0;
    st_d = st_q;
    if (st_q == SRun) begin
      unique case (cmd_q.action)
        ActInsert: begin
          if (rv_q && !ins_done_q && !(rdat.key < cmd_q.record_key)) ins_now = 1'b1;
          if (!rv_q && !ins_done_q) ins_tail = 1'b1;
          if (ins_now || ins_tail) begin
            we = 1'b1;
            wdat = '{key: cmd_q.record_key, date: cdate, handle: cmd_q.record_handle};
          end else if (rv_q) begin
            we = 1'b1;
          end
          if (!rv_q && (ins_done_q || ins_tail)) st_d = SDone;
        end
        ActFind: begin
          if (rv_q && rdat.date == cdate) begin
            emit = 1'b1;
            ew.status = StOk; ew.found_key = rdat.key; ew.found_handle = rdat.handle;
            {ew.found_year, ew.found_month, ew.found_day} = rdat.date;
            we = 1'b1;
          end else if (rv_q) begin
            we = 1'b1;
          end
          if (!rv_q) st_d = SDone;
        end
        default: begin
          keep = rv_q && rdat.date != cdate;
          we = keep;
          if (!rv_q) st_d = SDone;
        end
      endcase
    end
  end

  // a new match pushes the held one out, so it waits for the output register
  assign stall = (st_q == SRun) && emit && found_q && !out_free;

  // Output register: held match words, then the closing word of each command.
  always_comb begin
    ov_d = ov_q && !out_ready_i;
    ow_d = ow_q;
    if (st_q == SRun && emit && found_q && out_free) begin
      ov_d = 1'b1;
      ow_d = pend_q;
    end else if (st_q == SDone && out_free) begin
      ov_d = 1'b1;
      ow_d = '0;
      ow_d.last = 1'b1;
      unique case (cmd_q.action)
        ActInsert: begin
          if (wr_q == '0) ow_d.status = StFull;   // full: nothing written
        end
        ActFind: begin
          if (found_q) begin
            ow_d = pend_q;
            ow_d.last = 1'b1;
          end else begin
            ow_d.status = StNoMatch;
          end
        end
        default: begin
          ow_d.removed_count = rem_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) cmd_q <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; bank_q <= 1'b0; cnt_q <= '0; rd_q <= '0; wr_q <= '0;
      rv_q <= 1'b0; ins_done_q <= 1'b0; rem_q <= '0; found_q <= 1'b0;
      pend_q <= '0; ov_q <= 1'b0; ow_q <= '0;
    end else begin
      ov_q <= ov_d;
      ow_q <= ow_d;
      unique case (st_q)
        SIdle: begin
          if (cmd_pop_o) begin
            rd_q <= CntW'(1); wr_q <= '0; rv_q <= (cnt_q != '0);
            rem_q <= '0; found_q <= 1'b0;
            if (cmd_i.action == ActInsert && cnt_q == CntW'(Capacity)) begin
              st_q <= SDone; ins_done_q <= 1'b1;   // full: nothing written
            end else begin
              st_q <= SRun; ins_done_q <= 1'b0;
            end
          end
        end
        SRun: begin
          if (!stall) begin
            // issue next read; hold read while inserting ahead of current entry
            if (!ins_now) begin
              rv_q <= (rd_q < cnt_q);
              if (rd_q < cnt_q) rd_q <= rd_q + 1'b1;
            end
            if (we) wr_q <= wr_q + 1'b1;
            if (ins_now || ins_tail) ins_done_q <= 1'b1;
            if (rv_q && cmd_q.action == ActRemove && !keep) rem_q <= rem_q + 1'b1;
            if (emit) begin
              pend_q <= ew; found_q <= 1'b1;
            end
            st_q <= st_d;
          end
        end
        default: begin
          if (out_free) begin
            if (cmd_q.action == ActRemove || (cmd_q.action == ActInsert && wr_q != '0)) begin
              cnt_q <= wr_q; bank_q <= !bank_q;
            end
            st_q <= SIdle;
          end
        end
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_ready_i) |=> (ov_q && $stable(ow_q))) else $error("output word dropped");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Capacity)) else $error("entry count out of range");
  a_state_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q != 2'd3) else $error("illegal state");
endmodule

### src/sorted_record_table.sv
// Top level of the sorted record table: front queue plus table engine.
// Depends on srt_pkg, srt_front, srt_engine.
//  channel | direction | word
//  in      | in        | in_word_t  (action, key, date, handle)
//  out     | out       | out_word_t (status, record fields, count, last)
// A find or remove runs through the pop, a read of each table entry from the RAM, a step
// to see the end of the table and the close; an insert that lands ahead of an entry
// holds that entry's read while it writes the new key; a full table skips the walk.
// Reset clears the entry count; table RAM contents stay undefined.
// A waiting output word holds the engine; the front queue takes words until it is full.
module sorted_record_table import srt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_data_o
);
  logic     qv, qp;
  in_word_t qd;
  srt_front u_front (.clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .q_valid_o(qv), .q_pop_i(qp), .q_data_o(qd));
  srt_engine u_eng (.clk_i, .rst_ni, .cmd_valid_i(qv), .cmd_pop_o(qp), .cmd_i(qd),
    .out_valid_o, .out_ready_i, .out_data_o);
endmodule

### test/tb_sorted_record_table.sv
// Testbench for the sorted record table: random and directed insert, find and remove words.
// Depends on srt_pkg and the sorted_record_table RTL; a scoreboard class predicts the table.
`timescale 1ns / 1ps

module tb_sorted_record_table;
  import srt_pkg::*;

  // Table predictor and store of expected result words.
  class table_scoreboard;
    logic [55:0] keys[$];
    logic [20:0] dates[$];
    logic [15:0] handles[$];
    out_word_t   pending[$];
    int          errors;
    int          checked;

    function automatic out_word_t blank();
      out_word_t w;
      w = '0;
      return w;
    endfunction

    // Work out the result words of one accepted input word.
    function void note_input(in_word_t w);
      logic [20:0] d;
      out_word_t   r;
      int          pos;
      int          n;
      int          i;
      d = {w.birth_year, w.birth_month, w.birth_day};
      r = blank();
      r.last = 1'b1;
      if (w.action == ActInsert) begin
        if (keys.size() >= Capacity) begin
          r.status = StFull;
        end else begin
          pos = 0;
          while (pos < keys.size() && keys[pos] < w.record_key) pos++;
          keys.insert(pos, w.record_key);
          dates.insert(pos, d);
          handles.insert(pos, w.record_handle);
        end
        pending.push_back(r);
      end else if (w.action == ActFind) begin
        n = 0;
        for (i = 0; i < keys.size(); i++) begin
          if (dates[i] == d) begin
            r = blank();
            r.found_key = keys[i];
            {r.found_year, r.found_month, r.found_day} = dates[i];
            r.found_handle = handles[i];
            pending.push_back(r);
            n++;
          end
        end
        if (n == 0) begin
          r = blank();
          r.status = StNoMatch;
          r.last = 1'b1;
          pending.push_back(r);
        end else begin
          pending[pending.size()-1].last = 1'b1;
        end
      end else if (w.action == ActRemove) begin
        n = 0;
        for (i = keys.size() - 1; i >= 0; i--) begin
          if (dates[i] == d) begin
            keys.delete(i);
            dates.delete(i);
            handles.delete(i);
            n++;
          end
        end
        r.removed_count = n[5:0];
        pending.push_back(r);
      end
      // unused action code: ignored, nothing expected
    endfunction

    function void check_result(out_word_t a);
      out_word_t e;
      checked++;
      if (pending.size() == 0) begin
        $error("result word with nothing expected: %h", a);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.status !== e.status) begin
        $error("status exp %0d got %0d", e.status, a.status); errors++;
      end
      if (a.found_key !== e.found_key) begin
        $error("found_key exp %h got %h", e.found_key, a.found_key); errors++;
      end
      if (a.found_day !== e.found_day) begin
        $error("found_day exp %0d got %0d", e.found_day, a.found_day); errors++;
      end
      if (a.found_month !== e.found_month) begin
        $error("found_month exp %0d got %0d", e.found_month, a.found_month); errors++;
      end
      if (a.found_year !== e.found_year) begin
        $error("found_year exp %0d got %0d", e.found_year, a.found_year); errors++;
      end
      if (a.found_handle !== e.found_handle) begin
        $error("found_handle exp %h got %h", e.found_handle, a.found_handle); errors++;
      end
      if (a.removed_count !== e.removed_count) begin
        $error("removed_count exp %0d got %0d", e.removed_count, a.removed_count);
        errors++;
      end
      if (a.last !== e.last) begin
        $error("last exp %0d got %0d", e.last, a.last); errors++;
      end
    endfunction
  endclass

  localparam int WatchdogLimit = 20000;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;

  table_scoreboard sb;
  int  idle_cycles;
  int  words_sent;
  bit  timed_out;
  // small pool of dates so finds and removes hit often
  logic [20:0] date_pool[8];

  sorted_record_table u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Monitor: note inputs and check outputs at the rising edge; watchdog on stuck handshakes.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready) sb.note_input(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready) ||
          (!in_valid && sb.pending.size() == 0)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= WatchdogLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("watchdog: no words moved for %0d cycles", WatchdogLimit);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Receiver stalls: randomly chosen modes of steady ready, light random stalls and heavy random stalls.
  initial begin
    int mode;
    out_ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(10, 80)) begin
        @(negedge clk_i);
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Present one word and hold it until taken.
  task automatic send_word(in_word_t w);
    @(negedge clk_i);
    in_data  <= w;
    in_valid <= 1'b1;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    words_sent++;
  endtask

  // Drop valid for a random gap one time in four, else none.
  task automatic gap();
    int n;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
    if (n > 0) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (Capacity + 10) @(negedge clk_i);
  endtask

  function automatic in_word_t make_word(logic [1:0] act, logic [55:0] key,
                                         logic [20:0] d, logic [15:0] h);
    in_word_t w;
    w.action = act;
    w.record_key = key;
    {w.birth_year, w.birth_month, w.birth_day} = d;
    w.record_handle = h;
    return w;
  endfunction

  function automatic logic [55:0] rand_key();
    logic [55:0] k;
    k = 56'({$urandom, $urandom});
    case ($urandom_range(0, 4))
      0: k = '0;
      1: k = '1;
      2: k[55:48] = 8'(8'h41 + $urandom_range(0, 3)); // few distinct leading bytes, so keys often share one
      default: ;
    endcase
    if ($urandom_range(0, 3) == 0) k[31:0] = '0;
    return k;
  endfunction

  function automatic logic [20:0] rand_date();
    logic [20:0] d;
    d = 21'($urandom);
    if ($urandom_range(0, 4) != 0) d = date_pool[3'($urandom_range(0, 7))];
    return d;
  endfunction

  task automatic run_random(int count, int insert_weight);
    int i;
    int r;
    logic [1:0] act;
    for (i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < insert_weight) act = ActInsert;
      else if (r < insert_weight + (100 - insert_weight) / 2) act = ActFind;
      else if (r < 97) act = ActRemove;
      else act = ActNone;
      send_word(make_word(act, rand_key(), rand_date(), 16'($urandom)));
      gap();
    end
  endtask

  initial begin
    int i;
    sb = new();
    in_valid  = 1'b0;
    in_data   = '0;
    rst_ni    = 1'b0;
    idle_cycles = 0;
    words_sent  = 0;
    timed_out   = 1'b0;
    for (i = 0; i < 8; i++) date_pool[3'(i)] = 21'($urandom);
    date_pool[0] = '0;
    date_pool[1] = '1;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty table, key and date extremes, equal keys, full table, codes.
    send_word(make_word(ActFind, '0, '0, '0));
    send_word(make_word(ActRemove, '0, '1, '0));
    send_word(make_word(ActInsert, '1, '1, 16'hFFFF));
    send_word(make_word(ActInsert, '0, '0, 16'h0000));
    send_word(make_word(ActInsert, 56'h41424300000000, '1, 16'h0001));
    send_word(make_word(ActInsert, 56'h41424300000000, '1, 16'h0002)); // equal key, newest first
    send_word(make_word(ActNone, '1, '1, '1));
    send_word(make_word(ActFind, '0, '1, '0));
    send_word(make_word(ActFind, '0, '0, '0));
    send_word(make_word(ActRemove, '0, '1, '0));
    send_word(make_word(ActFind, '0, '1, '0));
    for (i = 0; i < Capacity; i++) begin
      send_word(make_word(ActInsert, rand_key(), date_pool[3'(i % 2)], i[15:0]));
    end
    send_word(make_word(ActInsert, '1, '1, '1)); // table full
    send_word(make_word(ActFind, '0, date_pool[0], '0));
    send_word(make_word(ActRemove, '0, date_pool[0], '0));
    send_word(make_word(ActRemove, '0, date_pool[1], '0));

    // Sender holds off until every result is back.
    wait_drained();

    run_random(135, 60);
    wait_drained();
    run_random(135, 80); // runs into a full table
    run_random(135, 40);
    wait_drained();

    $display("covered %0d input words, %0d result words checked, fill up to %0d",
             words_sent, sb.checked, Capacity);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
